### rtl/core/pbd_pkg.sv
// ----------------------------------------------------------------------------
// pbd_pkg: shared constants and types for point_box_distance
// Coordinate and fixed-point widths, derived datapath widths and the
// records handed along the square-root cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package pbd_pkg;

  // Field widths
  localparam int unsigned COORD_BITS = 21;
  localparam int unsigned FRAC_BITS  = 8;
  localparam int unsigned OUT_W      = 30;

  // Signed margin, magnitude, square and sum widths
  localparam int unsigned MARG_W = COORD_BITS + 1;
  localparam int unsigned MAG_W  = COORD_BITS;
  localparam int unsigned SQ_W   = 2 * MAG_W;
  localparam int unsigned SUM_W  = SQ_W + 1;

  // Root chain: one result bit per cell, two radicand bits per cell
  localparam int unsigned RAD_W      = 2 * OUT_W;
  localparam int unsigned REM_W      = OUT_W + 2;
  localparam int unsigned ROOT_SHIFT = 2 * OUT_W - 2 * FRAC_BITS;

  // Margin, square and sum stages, the cells, then the output register
  localparam int unsigned LATENCY = OUT_W + 4;

  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  // Result selection carried beside the root data
  typedef struct packed {
    logic             use_root;
    logic [OUT_W-1:0] bypass;
  } pbd_side_t;

  // Partial square-root state
  typedef struct packed {
    logic [RAD_W-1:0] rad;
    logic [REM_W-1:0] rem;
    logic [OUT_W-1:0] root;
  } pbd_root_t;

endpackage

`default_nettype wire

### rtl/core/pbd_margin.sv
// ----------------------------------------------------------------------------
// pbd_margin: corner ordering and edge margins
// Orders the corners on each axis, forms the smaller signed distance to the
// low and high edges and clamps positive margins to zero in solid mode.
// ----------------------------------------------------------------------------
`default_nettype none

module pbd_margin (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire                                      valid_i,
  input  wire logic signed [pbd_pkg::COORD_BITS-1:0] corner_a_x_i,
  input  wire logic signed [pbd_pkg::COORD_BITS-1:0] corner_a_y_i,
  input  wire logic signed [pbd_pkg::COORD_BITS-1:0] corner_b_x_i,
  input  wire logic signed [pbd_pkg::COORD_BITS-1:0] corner_b_y_i,
  input  wire logic signed [pbd_pkg::COORD_BITS-1:0] point_x_i,
  input  wire logic signed [pbd_pkg::COORD_BITS-1:0] point_y_i,
  input  wire                                      solid_mode_i,
  output logic                                     valid_o,
  output logic signed [pbd_pkg::MARG_W-1:0]        dx_o,
  output logic signed [pbd_pkg::MARG_W-1:0]        dy_o
);
  import pbd_pkg::*;

  logic signed [COORD_BITS-1:0] x_lo, x_hi, y_lo, y_hi;
  logic signed [MARG_W-1:0]     dx_lo, dx_hi, dy_lo, dy_hi;
  logic signed [MARG_W-1:0]     dx_m, dy_m, dx_d, dy_d;
  logic signed [MARG_W-1:0]     dx_q, dy_q;
  logic                         valid_q;

  // Order the corners into low and high bounds
  always_comb begin
    x_lo = (corner_a_x_i < corner_b_x_i) ? corner_a_x_i : corner_b_x_i;
    x_hi = (corner_a_x_i < corner_b_x_i) ? corner_b_x_i : corner_a_x_i;
    y_lo = (corner_a_y_i < corner_b_y_i) ? corner_a_y_i : corner_b_y_i;
    y_hi = (corner_a_y_i < corner_b_y_i) ? corner_b_y_i : corner_a_y_i;
  end

  // Take the nearer edge on each axis, clamp inside margins when solid
  always_comb begin
    dx_lo = MARG_W'(point_x_i) - MARG_W'(x_lo);
    dx_hi = MARG_W'(x_hi) - MARG_W'(point_x_i);
    dy_lo = MARG_W'(point_y_i) - MARG_W'(y_lo);
    dy_hi = MARG_W'(y_hi) - MARG_W'(point_y_i);
    dx_m  = (dx_lo < dx_hi) ? dx_lo : dx_hi;
    dy_m  = (dy_lo < dy_hi) ? dy_lo : dy_hi;
    dx_d  = (solid_mode_i && !dx_m[MARG_W-1]) ? '0 : dx_m;
    dy_d  = (solid_mode_i && !dy_m[MARG_W-1]) ? '0 : dy_m;
  end

  // Advance the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Capture the margins
  always_ff @(posedge clk_i) begin
    dx_q <= dx_d;
    dy_q <= dy_d;
  end

  assign valid_o = valid_q;
  assign dx_o    = dx_q;
  assign dy_o    = dy_q;

endmodule

`default_nettype wire

### rtl/core/pbd_square.sv
// ----------------------------------------------------------------------------
// pbd_square: magnitudes, squares and radicand
// Picks the result path, scales the direct result with saturation, squares
// both margins and sums them into the radicand of the root chain.
// ----------------------------------------------------------------------------
`default_nettype none

module pbd_square (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   valid_i,
  input  wire logic signed [pbd_pkg::MARG_W-1:0] dx_i,
  input  wire logic signed [pbd_pkg::MARG_W-1:0] dy_i,
  output logic                                  valid_o,
  output pbd_pkg::pbd_side_t                    side_o,
  output pbd_pkg::pbd_root_t                    data_o
);
  import pbd_pkg::*;

  logic             neg_x, neg_y;
  logic [MAG_W-1:0] mag_x, mag_y, mag_sel;
  logic [SQ_W-1:0]  sq_x_d, sq_y_d, sq_x_q, sq_y_q;
  pbd_side_t        side_d, side_q, side2_d, side2_q;
  logic [SUM_W-1:0] sum;
  logic             root_sat;
  logic [RAD_W-1:0] rad_d, rad_q;
  logic             valid_q, valid2_q;

  // Magnitudes and direct-path selection
  always_comb begin
    neg_x = dx_i[MARG_W-1];
    neg_y = dy_i[MARG_W-1];
    mag_x = MAG_W'(neg_x ? -dx_i : dx_i);
    mag_y = MAG_W'(neg_y ? -dy_i : dy_i);
    if (neg_x && !neg_y) begin
      mag_sel = mag_x;
    end else if (neg_y && !neg_x) begin
      mag_sel = mag_y;
    end else begin
      mag_sel = (mag_x < mag_y) ? mag_x : mag_y;
    end
    side_d.use_root = neg_x && neg_y;
    side_d.bypass   = ((mag_sel >> (OUT_W - FRAC_BITS)) != '0) ? OUT_MAX
                    : OUT_W'(mag_sel) << FRAC_BITS;
    sq_x_d = mag_x * mag_x;
    sq_y_d = mag_y * mag_y;
  end

  // Sum the squares, saturate roots that would overflow the output
  always_comb begin
    sum      = SUM_W'(sq_x_q) + SUM_W'(sq_y_q);
    root_sat = (sum >> ROOT_SHIFT) != '0;
    rad_d    = RAD_W'(sum) << (2 * FRAC_BITS);
    side2_d  = side_q;
    if (side_q.use_root && root_sat) begin
      side2_d.use_root = 1'b0;
      side2_d.bypass   = OUT_MAX;
    end
  end

  // Advance the valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      valid_q  <= valid_i;
      valid2_q <= valid_q;
    end
  end

  // Capture squares, then the radicand
  always_ff @(posedge clk_i) begin
    sq_x_q  <= sq_x_d;
    sq_y_q  <= sq_y_d;
    side_q  <= side_d;
    rad_q   <= rad_d;
    side2_q <= side2_d;
  end

  assign valid_o = valid2_q;
  assign side_o  = side2_q;
  always_comb begin
    data_o.rad  = rad_q;
    data_o.rem  = '0;
    data_o.root = '0;
  end

endmodule

`default_nettype wire

### rtl/core/pbd_root_cell.sv
// ----------------------------------------------------------------------------
// pbd_root_cell: one digit of the square-root chain
// Brings down two radicand bits, tries the next root bit by compare and
// subtract, and hands the partial root to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module pbd_root_cell (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      valid_i,
  input  wire pbd_pkg::pbd_side_t  side_i,
  input  wire pbd_pkg::pbd_root_t  data_i,
  output logic                     valid_o,
  output pbd_pkg::pbd_side_t       side_o,
  output pbd_pkg::pbd_root_t       data_o
);
  import pbd_pkg::*;

  logic [REM_W-1:0] rem_sh, trial;
  logic             fits;
  pbd_root_t        data_d, data_q;
  pbd_side_t        side_q;
  logic             valid_q;

  // Try the next root bit
  always_comb begin
    rem_sh      = {data_i.rem[REM_W-3:0], data_i.rad[RAD_W-1 -: 2]};
    trial       = {data_i.root, 2'b01};
    fits        = rem_sh >= trial;
    data_d.rem  = fits ? rem_sh - trial : rem_sh;
    data_d.root = {data_i.root[OUT_W-2:0], fits};
    data_d.rad  = data_i.rad << 2;
  end

  // Advance the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Hand the partial root and side data on
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign data_o  = data_q;

`ifndef NO_ASSERTIONS
  // The remainder never exceeds twice the partial root
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> data_q.rem <= REM_W'({data_q.root, 1'b0}))
    else $error("root cell remainder out of range");
`endif

endmodule

`default_nettype wire

### rtl/core/point_box_distance.sv
// ----------------------------------------------------------------------------
// point_box_distance: shortest distance from a point to an axis-aligned box
// Margin stage, square stage and a row of square-root cells; the result is
// unsigned fixed point with FRAC_BITS fraction bits, rounded down.
// ----------------------------------------------------------------------------
//  channel   ports                              transfer
//  command   start_i, busy_o, corner/point/solid start_i && !busy_o
//  result    done_o, distance_fixed_o           done_o, one cycle
//
//  One item is taken in every cycle; busy_o stays low.
//  The path runs through the margin, square and sum registers, the 30-cell
//  square-root row, one result bit per cell, and the output register.
//  Reset clears the valid flags of every stage; data registers are not reset.
//  The receiver cannot stall; done_o pulses for one cycle per result.
// ----------------------------------------------------------------------------
`default_nettype none

module point_box_distance (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire                                      start_i,
  output logic                                     busy_o,
  input  wire logic signed [pbd_pkg::COORD_BITS-1:0] corner_a_x_i,
  input  wire logic signed [pbd_pkg::COORD_BITS-1:0] corner_a_y_i,
  input  wire logic signed [pbd_pkg::COORD_BITS-1:0] corner_b_x_i,
  input  wire logic signed [pbd_pkg::COORD_BITS-1:0] corner_b_y_i,
  input  wire logic signed [pbd_pkg::COORD_BITS-1:0] point_x_i,
  input  wire logic signed [pbd_pkg::COORD_BITS-1:0] point_y_i,
  input  wire                                      solid_mode_i,
  output logic                                     done_o,
  output logic [pbd_pkg::OUT_W-1:0]                distance_fixed_o
);
  import pbd_pkg::*;

  logic                     accept;
  logic                     marg_valid;
  logic signed [MARG_W-1:0] marg_dx, marg_dy;
  logic                     valid_c [OUT_W+1];
  pbd_side_t                side_c  [OUT_W+1];
  pbd_root_t                data_c  [OUT_W+1];
  logic                     done_q;
  logic [OUT_W-1:0]         dist_d, dist_q;

  // The pipeline never stalls
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  pbd_margin u_margin (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (accept),
    .corner_a_x_i (corner_a_x_i),
    .corner_a_y_i (corner_a_y_i),
    .corner_b_x_i (corner_b_x_i),
    .corner_b_y_i (corner_b_y_i),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .solid_mode_i (solid_mode_i),
    .valid_o      (marg_valid),
    .dx_o         (marg_dx),
    .dy_o         (marg_dy)
  );

  pbd_square u_square (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (marg_valid),
    .dx_i    (marg_dx),
    .dy_i    (marg_dy),
    .valid_o (valid_c[0]),
    .side_o  (side_c[0]),
    .data_o  (data_c[0])
  );

  // Row of root cells, one result bit each
  for (genvar g = 0; g < OUT_W; g++) begin : g_cell
    pbd_root_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_c[g]),
      .side_i  (side_c[g]),
      .data_i  (data_c[g]),
      .valid_o (valid_c[g+1]),
      .side_o  (side_c[g+1]),
      .data_o  (data_c[g+1])
    );
  end

  // Select root or direct result
  assign dist_d = side_c[OUT_W].use_root ? data_c[OUT_W].root : side_c[OUT_W].bypass;

  // Strobe the result out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_c[OUT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
  end

  assign done_o           = done_q;
  assign distance_fixed_o = dist_q;

`ifndef NO_ASSERTIONS
  // Every result comes from an earlier command
  a_done_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LATENCY))
    else $error("result without matching command");

  // A point on a box corner is at distance zero
  a_corner_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && point_x_i == corner_a_x_i && point_y_i == corner_a_y_i)
    |-> ##LATENCY (done_o && distance_fixed_o == '0))
    else $error("corner point gave nonzero distance");
`endif

endmodule

`default_nettype wire

### bench/point_box_distance_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_box_distance_tb: self-checking bench for point_box_distance
// Drives box/point queries through the command port with random gaps.
// A scoreboard predicts each floored fixed-point distance and compares
// every done_o strobe against the oldest pending prediction.
// ----------------------------------------------------------------------------

// One query as seen on the command port
typedef struct {
  logic signed [pbd_pkg::COORD_BITS-1:0] corner_a_x;
  logic signed [pbd_pkg::COORD_BITS-1:0] corner_a_y;
  logic signed [pbd_pkg::COORD_BITS-1:0] corner_b_x;
  logic signed [pbd_pkg::COORD_BITS-1:0] corner_b_y;
  logic signed [pbd_pkg::COORD_BITS-1:0] point_x;
  logic signed [pbd_pkg::COORD_BITS-1:0] point_y;
  logic                                  solid_mode;
} box_query_t;

// Predicts distances for accepted queries and matches them against results
class distance_board;
  logic [pbd_pkg::OUT_W-1:0] pending_dist[$];
  int unsigned               fail_count;

  function new();
    fail_count = 0;
  endfunction

  // Scale a magnitude to fixed point, saturate to the output width
  function logic [pbd_pkg::OUT_W-1:0] to_fixed(longint unsigned mag);
    longint unsigned out_max;
    out_max = (64'd1 << pbd_pkg::OUT_W) - 1;
    if (mag > (out_max >> pbd_pkg::FRAC_BITS)) return pbd_pkg::OUT_MAX;
    return pbd_pkg::OUT_W'(mag << pbd_pkg::FRAC_BITS);
  endfunction

  // floor(sqrt(sum) * 2^FRAC_BITS), saturated
  function logic [pbd_pkg::OUT_W-1:0] root_to_fixed(longint unsigned sum);
    longint unsigned rad;
    longint unsigned root;
    longint unsigned trial;
    if (sum >= (64'd1 << (2 * pbd_pkg::OUT_W - 2 * pbd_pkg::FRAC_BITS)))
      return pbd_pkg::OUT_MAX;
    rad  = sum << (2 * pbd_pkg::FRAC_BITS);
    root = 0;
    for (int b = pbd_pkg::OUT_W - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= rad) root = trial;
    end
    return pbd_pkg::OUT_W'(root);
  endfunction

  // Shortest distance from the point to the box, fixed point
  function logic [pbd_pkg::OUT_W-1:0] nearest_distance(box_query_t q);
    longint lo_x, hi_x, lo_y, hi_y, px, py, dx, dy;
    longint ax, ay, bx, by;
    ax = q.corner_a_x;
    ay = q.corner_a_y;
    bx = q.corner_b_x;
    by = q.corner_b_y;
    px = q.point_x;
    py = q.point_y;
    lo_x = (ax < bx) ? ax : bx;
    hi_x = (ax < bx) ? bx : ax;
    lo_y = (ay < by) ? ay : by;
    hi_y = (ay < by) ? by : ay;
    dx = ((px - lo_x) < (hi_x - px)) ? (px - lo_x) : (hi_x - px);
    dy = ((py - lo_y) < (hi_y - py)) ? (py - lo_y) : (hi_y - py);
    // Filled box: the interior is at distance zero
    if (q.solid_mode) begin
      if (dx > 0) dx = 0;
      if (dy > 0) dy = 0;
    end
    if (dx < 0 && dy < 0) return root_to_fixed(dx * dx + dy * dy);
    if (dx < 0) return to_fixed(-dx);
    if (dy < 0) return to_fixed(-dy);
    return to_fixed((dx < dy) ? dx : dy);
  endfunction

  // Record the prediction for an accepted query
  function void note_query(box_query_t q);
    pending_dist.push_back(nearest_distance(q));
  endfunction

  // Compare one result with the oldest prediction
  function void check_distance(logic [pbd_pkg::OUT_W-1:0] actual);
    logic [pbd_pkg::OUT_W-1:0] expected;
    if (pending_dist.size() == 0) begin
      $error("distance_fixed: no result expected, actual %0d", actual);
      fail_count++;
      return;
    end
    expected = pending_dist.pop_front();
    if (actual !== expected) begin
      $error("distance_fixed: expected %0d, actual %0d", expected, actual);
      fail_count++;
    end
  endfunction
endclass

module point_box_distance_tb;
  import pbd_pkg::*;

  localparam int          MIN_C          = -(1 << (COORD_BITS - 1));
  localparam int          MAX_C          = (1 << (COORD_BITS - 1)) - 1;
  localparam int          NUM_RANDOM     = 1900;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start_i;
  logic                         busy_o;
  logic signed [COORD_BITS-1:0] corner_a_x_i;
  logic signed [COORD_BITS-1:0] corner_a_y_i;
  logic signed [COORD_BITS-1:0] corner_b_x_i;
  logic signed [COORD_BITS-1:0] corner_b_y_i;
  logic signed [COORD_BITS-1:0] point_x_i;
  logic signed [COORD_BITS-1:0] point_y_i;
  logic                         solid_mode_i;
  logic                         done_o;
  logic [OUT_W-1:0]             distance_fixed_o;

  distance_board sb = new();
  box_query_t    seen_q;
  int unsigned   stall_cycles;

  point_box_distance dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .corner_a_x_i     (corner_a_x_i),
    .corner_a_y_i     (corner_a_y_i),
    .corner_b_x_i     (corner_b_x_i),
    .corner_b_y_i     (corner_b_y_i),
    .point_x_i        (point_x_i),
    .point_y_i        (point_y_i),
    .solid_mode_i     (solid_mode_i),
    .done_o           (done_o),
    .distance_fixed_o (distance_fixed_o)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watch both ports: note command transfers, check results, guard progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        seen_q.corner_a_x = corner_a_x_i;
        seen_q.corner_a_y = corner_a_y_i;
        seen_q.corner_b_x = corner_b_x_i;
        seen_q.corner_b_y = corner_b_y_i;
        seen_q.point_x    = point_x_i;
        seen_q.point_y    = point_y_i;
        seen_q.solid_mode = solid_mode_i;
        sb.note_query(seen_q);
      end
      if (done_o) sb.check_distance(distance_fixed_o);
      if ((start_i && !busy_o) || done_o) begin
        stall_cycles = 0;
      end else begin
        stall_cycles = stall_cycles + 1;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("** point_box_distance: FAILED **");
        $finish;
      end
    end
  end

  function automatic logic signed [COORD_BITS-1:0] rand_coord();
    return COORD_BITS'($urandom());
  endfunction

  function automatic int spread(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic box_query_t make_query(int ax, int ay, int bx, int by,
                                            int px, int py, bit solid);
    box_query_t q;
    q.corner_a_x = COORD_BITS'(ax);
    q.corner_a_y = COORD_BITS'(ay);
    q.corner_b_x = COORD_BITS'(bx);
    q.corner_b_y = COORD_BITS'(by);
    q.point_x    = COORD_BITS'(px);
    q.point_y    = COORD_BITS'(py);
    q.solid_mode = solid;
    return q;
  endfunction

  // Present one query and hold it until the transfer
  task automatic send_query(box_query_t q);
    start_i      <= 1'b1;
    corner_a_x_i <= q.corner_a_x;
    corner_a_y_i <= q.corner_a_y;
    corner_b_x_i <= q.corner_b_x;
    corner_b_y_i <= q.corner_b_y;
    point_x_i    <= q.point_x;
    point_y_i    <= q.point_y;
    solid_mode_i <= q.solid_mode;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Drop start for one cycle, scramble the idle payload
  task automatic idle_cycle();
    start_i      <= 1'b0;
    corner_a_x_i <= rand_coord();
    corner_a_y_i <= rand_coord();
    corner_b_x_i <= rand_coord();
    corner_b_y_i <= rand_coord();
    point_x_i    <= rand_coord();
    point_y_i    <= rand_coord();
    solid_mode_i <= 1'($urandom());
    @(posedge clk_i);
  endtask

  task automatic send_box(int ax, int ay, int bx, int by, int px, int py, bit solid);
    send_query(make_query(ax, ay, bx, by, px, py, solid));
  endtask

  // Random query: full range, or a box and point clustered at some scale
  function automatic box_query_t random_query();
    box_query_t q;
    int         kind;
    int         span;
    int         cx;
    int         cy;
    kind = $urandom_range(0, 3);
    if (kind == 0) begin
      q.corner_a_x = rand_coord();
      q.corner_a_y = rand_coord();
      q.corner_b_x = rand_coord();
      q.corner_b_y = rand_coord();
      q.point_x    = rand_coord();
      q.point_y    = rand_coord();
    end else begin
      span = (kind == 1) ? 16 : (kind == 2) ? 4096 : (1 << 18);
      cx   = int'($urandom_range(0, 1 << 19)) - (1 << 18);
      cy   = int'($urandom_range(0, 1 << 19)) - (1 << 18);
      q.corner_a_x = COORD_BITS'(cx + spread(span));
      q.corner_a_y = COORD_BITS'(cy + spread(span));
      q.corner_b_x = COORD_BITS'(cx + spread(span));
      q.corner_b_y = COORD_BITS'(cy + spread(span));
      q.point_x    = COORD_BITS'(cx + spread(2 * span));
      q.point_y    = COORD_BITS'(cy + spread(2 * span));
    end
    q.solid_mode = 1'($urandom());
    return q;
  endfunction

  // Stimulus and end of run
  initial begin
    stall_cycles  = 0;
    rst_ni       <= 1'b0;
    start_i      <= 1'b0;
    corner_a_x_i <= '0;
    corner_a_y_i <= '0;
    corner_b_x_i <= '0;
    corner_b_y_i <= '0;
    point_x_i    <= '0;
    point_y_i    <= '0;
    solid_mode_i <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Full-range box with a point on a corner and at the centre
    send_box(MIN_C, MIN_C, MAX_C, MAX_C, MIN_C, MIN_C, 1'b0);
    send_box(MAX_C, MAX_C, MIN_C, MIN_C, 0, 0, 1'b0);
    send_box(MIN_C, MAX_C, MAX_C, MIN_C, 0, 0, 1'b1);
    // Point boxes far away: largest roots
    send_box(0, 0, 0, 0, MAX_C, MAX_C, 1'b0);
    send_box(MAX_C, MAX_C, MAX_C, MAX_C, MIN_C, MIN_C, 1'b1);
    send_box(MIN_C, MIN_C, MIN_C, MIN_C, MAX_C, MAX_C, 1'b0);
    // Corners reversed on the x axis, point inside
    send_box(100, -50, -100, 50, 0, 0, 1'b0);
    send_box(100, -50, -100, 50, 0, 0, 1'b1);
    // Outside on one axis, then on both
    send_box(-10, -10, 10, 10, 25, 3, 1'b0);
    send_box(-10, -10, 10, 10, 0, -40, 1'b1);
    send_box(-10, -10, 10, 10, 13, 14, 1'b0);
    send_box(-10, -10, 10, 10, 11, 11, 1'b1);
    send_box(-10, -10, 10, 10, -11, 12, 1'b0);
    // Point on an edge
    send_box(-10, -10, 10, 10, 10, 0, 1'b0);
    // Degenerate boxes
    send_box(5, -20, 5, 20, 5, 0, 1'b0);
    send_box(5, 7, 5, 7, 5, 7, 1'b0);
    send_box(5, 7, 5, 7, 5, 7, 1'b1);
    send_box(5, 7, 5, 7, 12, 4, 1'b0);
    // Largest single-axis margins
    send_box(MAX_C, -1, MAX_C, 1, MIN_C, 0, 1'b0);
    send_box(-1, MIN_C, 1, MIN_C, 0, MAX_C, 1'b1);
    // Interior near a corner, hollow and filled, then a point outside
    send_box(0, 0, 1000, 1000, 3, 900, 1'b0);
    send_box(0, 0, 1000, 1000, 3, 900, 1'b1);
    send_box(0, 0, 1000, 1000, 1200, 900, 1'b1);

    // Random queries with occasional gaps, one long back-to-back stretch
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (!(i >= 700 && i < 1200) && $urandom_range(0, 99) < 6) begin
        idle_cycle();
      end
      send_query(random_query());
    end

    // Drain the pipeline
    idle_cycle();
    while (sb.pending_dist.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);

    if (sb.fail_count == 0 && sb.pending_dist.size() == 0) begin
      $display("** point_box_distance: PASSED **");
    end else begin
      $display("** point_box_distance: FAILED **");
    end
    $finish;
  end

endmodule
